### rtl/dbd_pkg.sv
// Shared types, constants and calendar tables for the date difference pipeline.
package dbd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned DAYNUM_W = 24;

  localparam int unsigned DEF_MAX_YEAR = 9999;

  // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned QUOT_W      = 8;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               count_end_day;
  } dbd_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               bad_date;
  } dbd_out_t;

  // Length of a month; months outside 1..12 give 0.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m (non-leap).
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/days_between_dates.sv
// Gregorian date difference: four-stage pipeline from two dates to a day count.
// Throughput: one word per cycle while out_stall is low.
// Each stage holds its own valid bit, so a stall only backs up into empty slots.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline then reads empty.
module days_between_dates #(
  parameter int unsigned MAX_YEAR = dbd_pkg::DEF_MAX_YEAR
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dbd_pkg::dbd_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output dbd_pkg::dbd_out_t out_data
);
  import dbd_pkg::*;

  // lane 0 is the start date, lane 1 the end date
  logic [YEAR_W-1:0]  yin [2];
  logic [MONTH_W-1:0] min [2];
  logic [DAY_W-1:0]   din [2];

  assign yin[0] = in_data.start_year;
  assign min[0] = in_data.start_month;
  assign din[0] = in_data.start_day;
  assign yin[1] = in_data.end_year;
  assign min[1] = in_data.end_month;
  assign din[1] = in_data.end_day;

  // valid bits and ready chain
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_valid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  // Stage 1: year / 100 by reciprocal multiply
  logic [YEAR_W-1:0]  y1_r [2];
  logic [MONTH_W-1:0] m1_r [2];
  logic [DAY_W-1:0]   d1_r [2];
  logic [QUOT_W-1:0]  q1_r [2];
  logic [QUOT_W-1:0]  q1_nxt [2];
  logic               plus1_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      logic [YEAR_W+13:0] prod;
      prod      = (YEAR_W+14)'(yin[i]) * (YEAR_W+14)'(RECIP_100);
      q1_nxt[i] = prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 2; i++) begin
        y1_r[i] <= yin[i];
        m1_r[i] <= min[i];
        d1_r[i] <= din[i];
        q1_r[i] <= q1_nxt[i];
      end
      plus1_r <= in_data.count_end_day;
    end
  end

  // Stage 2: leap test, date check, day of year, previous year and its hundreds
  logic [YEAR_W-1:0] p2_r [2];
  logic [YEAR_W-1:0] p2_nxt [2];
  logic [QUOT_W-1:0] qp2_r [2];
  logic [QUOT_W-1:0] qp2_nxt [2];
  logic [8:0]        part2_r [2];
  logic [8:0]        part2_nxt [2];
  logic              bad2_r, bad2_nxt, plus2_r;

  always_comb begin
    bad2_nxt = 1'b0;
    for (int i = 0; i < 2; i++) begin
      logic [YEAR_W-1:0] hund;
      logic [YEAR_W-1:0] rem;
      logic              rem_zero;
      logic              leap;
      logic              year_ok;
      logic              month_ok;
      logic              day_ok;
      logic [DAY_W-1:0]  len;
      hund     = YEAR_W'({{(YEAR_W-QUOT_W){1'b0}}, q1_r[i]} * YEAR_W'(100));
      rem      = y1_r[i] - hund;
      rem_zero = (rem == '0);
      leap     = (y1_r[i][1:0] == 2'b00) && (!rem_zero || (q1_r[i][1:0] == 2'b00));
      year_ok  = (y1_r[i] != '0) && ({1'b0, y1_r[i]} <= 15'(MAX_YEAR));
      month_ok = m1_r[i] inside {[MONTH_JAN:MONTH_DEC]};
      len      = month_len(m1_r[i], leap);
      day_ok   = (d1_r[i] != '0) && (d1_r[i] <= len);
      if (!(year_ok && month_ok && day_ok)) bad2_nxt = 1'b1;
      p2_nxt[i]    = y1_r[i] - YEAR_W'(1);
      // (y-1)/100 drops by one exactly when y is a multiple of 100
      qp2_nxt[i]   = q1_r[i] - QUOT_W'(rem_zero);
      part2_nxt[i] = days_before(m1_r[i]) + 9'(d1_r[i])
                   + 9'((m1_r[i] > MONTH_FEB) && leap);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < 2; i++) begin
        p2_r[i]    <= p2_nxt[i];
        qp2_r[i]   <= qp2_nxt[i];
        part2_r[i] <= part2_nxt[i];
      end
      bad2_r  <= bad2_nxt;
      plus2_r <= plus1_r;
    end
  end

  // Stage 3: absolute day number
  logic [DAYNUM_W-1:0] n3_r [2];
  logic [DAYNUM_W-1:0] n3_nxt [2];
  logic                bad3_r, plus3_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      n3_nxt[i] = DAYNUM_W'(p2_r[i]) * DAYNUM_W'(365)
                + DAYNUM_W'(p2_r[i] >> 2)
                - DAYNUM_W'(qp2_r[i])
                + DAYNUM_W'(qp2_r[i] >> 2)
                + DAYNUM_W'(part2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      n3_r[0] <= n3_nxt[0];
      n3_r[1] <= n3_nxt[1];
      bad3_r  <= bad2_r;
      plus3_r <= plus2_r;
    end
  end

  // Stage 4: difference (zero if end precedes start), end-day add, saturate; bad dates give zero
  dbd_out_t out_r, out_nxt;

  always_comb begin
    logic [DAYNUM_W-1:0] diff;
    logic [DAYNUM_W:0]   total;
    diff  = (n3_r[1] > n3_r[0]) ? (n3_r[1] - n3_r[0]) : '0;
    total = {1'b0, diff} + (DAYNUM_W+1)'(plus3_r);
    out_nxt.bad_date = bad3_r;
    if (bad3_r) begin
      out_nxt.day_count = '0;
    end else if (total > (DAYNUM_W+1)'({COUNT_W{1'b1}})) begin
      out_nxt.day_count = '1;
    end else begin
      out_nxt.day_count = total[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/days_between_dates_chk.sv
// Port-level checker for the date difference pipeline, bound to the top level.
module days_between_dates_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input dbd_pkg::dbd_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input dbd_pkg::dbd_out_t out_data
);
  import dbd_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  // a held result word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // a bad date always reports a zero count
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_date |-> out_data.day_count == '0)
    else $error("bad date with nonzero count");

  // input backs up only when the output side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

endmodule

bind days_between_dates days_between_dates_chk u_chk (.*);
